// File: src/rrp_pkg.sv
// Shared types and constants for the RESP request parser.
// Depends on nothing; every other file of the parser imports it.
package rrp_pkg;

   // Datapath sizing. Lengths and counts are held to these widths.
   localparam int LenBits   = 32;
   localparam int CountBits = 21;

   // Fixed widths of the configuration registers and result fields.
   localparam int StrCfgBits      = 32;
   localparam int ArrCfgBits      = 21;
   localparam int CsrDataBits     = 32;
   localparam int CsrIndexBits    = 2;
   localparam int StringIndexBits = 21;
   localparam int OffsetBits      = 32;

   // Compare widths for the decimal accumulators (value * 10 + digit).
   localparam int ArrCmpBits = (CountBits + 4 > ArrCfgBits) ? CountBits + 4 : ArrCfgBits;
   localparam int StrCmpBits = (LenBits + 4 > StrCfgBits) ? LenBits + 4 : StrCfgBits;

   localparam logic [7:0] CharStar   = 8'h2A;
   localparam logic [7:0] CharDollar = 8'h24;
   localparam logic [7:0] CharCr     = 8'h0D;
   localparam logic [7:0] CharLf     = 8'h0A;
   localparam logic [7:0] CharZero   = 8'h30;
   localparam logic [7:0] CharNine   = 8'h39;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_MAX_STRING_LENGTH = 2'd0,
      CSR_MAX_ARRAY_LENGTH  = 2'd1
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_ARR_MARK  = 4'd0,
      PH_ARR_FIRST = 4'd1,
      PH_ARR_LEN   = 4'd2,
      PH_ARR_LF    = 4'd3,
      PH_STR_MARK  = 4'd4,
      PH_STR_FIRST = 4'd5,
      PH_STR_LEN   = 4'd6,
      PH_STR_LF    = 4'd7,
      PH_DATA      = 4'd8,
      PH_TRAIL_CR  = 4'd9,
      PH_TRAIL_LF  = 4'd10
   } phase_type;

   typedef enum logic [2:0] {
      EV_FRAME   = 3'd0,
      EV_PAYLOAD = 3'd1,
      EV_STRING  = 3'd2,
      EV_REQUEST = 3'd3,
      EV_ERROR   = 3'd4
   } event_type;

   typedef enum logic [3:0] {
      ERR_NONE      = 4'd0,
      ERR_ARR_MARK  = 4'd1,
      ERR_ARR_DIGIT = 4'd2,
      ERR_ARR_LONG  = 4'd3,
      ERR_ARR_CR    = 4'd4,
      ERR_ARR_LF    = 4'd5,
      ERR_STR_MARK  = 4'd6,
      ERR_STR_DIGIT = 4'd7,
      ERR_STR_LONG  = 4'd8,
      ERR_STR_CR    = 4'd9,
      ERR_STR_LF    = 4'd10,
      ERR_TRAIL_CR  = 4'd11,
      ERR_TRAIL_LF  = 4'd12
   } err_type;

   // One word held in the input register.
   typedef struct packed {
      logic       valid;
      logic [7:0] byte_in;
   } in_word_type;

   // One result word.
   typedef struct packed {
      event_type                  event_res;
      logic [7:0]                 data_byte;
      logic [StringIndexBits-1:0] string_index;
      logic [OffsetBits-1:0]      byte_offset;
      err_type                    error_code;
   } result_type;

endpackage

// File: src/rrp_in_stage.sv
// Input register of the RESP request parser: holds one byte until the core takes it.
// Depends on rrp_pkg.
module rrp_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_byte_in,
   input  logic                advance,
   output rrp_pkg::in_word_type word_out
);
   import rrp_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       accept;

   // Only a held word that cannot move on blocks the input.
   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign valid_in  = accept || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_byte_in;
      end
   end

   assign word_out.valid   = valid_ff;
   assign word_out.byte_in = byte_ff;

endmodule

// File: src/rrp_parser.sv
// Frame state machine of the RESP request parser: classifies one byte per step.
// Depends on rrp_pkg; the result is registered by rrp_out_stage.
module rrp_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  logic [7:0]                   byte_in,
   input  logic [rrp_pkg::StrCfgBits-1:0] max_string_length,
   input  logic [rrp_pkg::ArrCfgBits-1:0] max_array_length,
   output rrp_pkg::result_type          result
);
   import rrp_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [CountBits-1:0]   count_ff, count_in;
   logic [CountBits-1:0]   done_ff, done_in;
   logic [LenBits-1:0]     target_ff, target_in;
   logic [LenBits-1:0]     progress_ff, progress_in;

   logic                   is_digit;
   logic [3:0]             digit;
   logic                   arr_first, str_first;
   logic [ArrCmpBits-1:0]  arr_cfg, arr_mask, arr_lim, arr_base, arr_acc;
   logic [StrCmpBits-1:0]  str_cfg, str_mask, str_lim, str_base, str_acc;
   logic                   arr_long, str_long;
   logic [LenBits-1:0]     progress_inc;
   logic                   last_string;
   err_type                err;

   assign is_digit  = (byte_in >= CharZero) && (byte_in <= CharNine);
   assign digit     = 4'(byte_in - CharZero);
   assign arr_first = (phase_ff == PH_ARR_FIRST);
   assign str_first = (phase_ff == PH_STR_FIRST);

   // Limits are the register value, capped at what the count fields can hold.
   assign arr_cfg  = ArrCmpBits'(max_array_length);
   assign arr_mask = ArrCmpBits'({CountBits{1'b1}});
   assign arr_lim  = (arr_cfg < arr_mask) ? arr_cfg : arr_mask;
   assign str_cfg  = StrCmpBits'(max_string_length);
   assign str_mask = StrCmpBits'({LenBits{1'b1}});
   assign str_lim  = (str_cfg < str_mask) ? str_cfg : str_mask;

   // value * 10 + digit, as two shifts and adds
   assign arr_base = arr_first ? '0 : ArrCmpBits'(count_ff);
   assign arr_acc  = (arr_base << 3) + (arr_base << 1) + ArrCmpBits'(digit);
   assign str_base = str_first ? '0 : StrCmpBits'(target_ff);
   assign str_acc  = (str_base << 3) + (str_base << 1) + StrCmpBits'(digit);
   assign arr_long = arr_acc > arr_lim;
   assign str_long = str_acc > str_lim;

   assign progress_inc = progress_ff + LenBits'(1);
   assign last_string  = ({1'b0, done_ff} + (CountBits + 1)'(1)) >= {1'b0, count_ff};

   // Error classification of the current byte
   always_comb begin
      err = ERR_NONE;
      unique case (phase_ff)
         PH_ARR_MARK: begin
            if (byte_in != CharStar) err = ERR_ARR_MARK;
         end
         PH_ARR_FIRST, PH_ARR_LEN: begin
            if (is_digit) begin
               if (arr_long) err = ERR_ARR_LONG;
            end else if (arr_first) begin
               err = ERR_ARR_DIGIT;
            end else if (byte_in != CharCr) begin
               err = ERR_ARR_CR;
            end
         end
         PH_ARR_LF: begin
            if (byte_in != CharLf) err = ERR_ARR_LF;
         end
         PH_STR_MARK: begin
            if (byte_in != CharDollar) err = ERR_STR_MARK;
         end
         PH_STR_FIRST, PH_STR_LEN: begin
            if (is_digit) begin
               if (str_long) err = ERR_STR_LONG;
            end else if (str_first) begin
               err = ERR_STR_DIGIT;
            end else if (byte_in != CharCr) begin
               err = ERR_STR_CR;
            end
         end
         PH_STR_LF: begin
            if (byte_in != CharLf) err = ERR_STR_LF;
         end
         PH_TRAIL_CR: begin
            if (byte_in != CharCr) err = ERR_TRAIL_CR;
         end
         PH_TRAIL_LF: begin
            if (byte_in != CharLf) err = ERR_TRAIL_LF;
         end
         default: begin
            err = ERR_NONE;
         end
      endcase
   end

   // Next state
   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      done_in     = done_ff;
      target_in   = target_ff;
      progress_in = progress_ff;
      if (err != ERR_NONE) begin
         phase_in    = PH_ARR_MARK;
         count_in    = '0;
         done_in     = '0;
         target_in   = '0;
         progress_in = '0;
      end else begin
         unique case (phase_ff)
            PH_ARR_MARK: begin
               phase_in = PH_ARR_FIRST;
            end
            PH_ARR_FIRST, PH_ARR_LEN: begin
               if (is_digit) begin
                  count_in = arr_acc[CountBits-1:0];
                  phase_in = PH_ARR_LEN;
               end else begin
                  phase_in = PH_ARR_LF;
               end
            end
            PH_ARR_LF: begin
               // empty request completes at once
               if (count_ff == '0) begin
                  phase_in = PH_ARR_MARK;
               end else begin
                  phase_in = PH_STR_MARK;
               end
            end
            PH_STR_MARK: begin
               phase_in = PH_STR_FIRST;
            end
            PH_STR_FIRST, PH_STR_LEN: begin
               if (is_digit) begin
                  target_in = str_acc[LenBits-1:0];
                  phase_in  = PH_STR_LEN;
               end else begin
                  phase_in = PH_STR_LF;
               end
            end
            PH_STR_LF: begin
               progress_in = '0;
               phase_in    = (target_ff == '0) ? PH_TRAIL_CR : PH_DATA;
            end
            PH_DATA: begin
               progress_in = progress_inc;
               if (progress_inc >= target_ff) phase_in = PH_TRAIL_CR;
            end
            PH_TRAIL_CR: begin
               phase_in = PH_TRAIL_LF;
            end
            PH_TRAIL_LF: begin
               if (last_string) begin
                  phase_in    = PH_ARR_MARK;
                  count_in    = '0;
                  done_in     = '0;
                  target_in   = '0;
                  progress_in = '0;
               end else begin
                  phase_in    = PH_STR_MARK;
                  done_in     = done_ff + CountBits'(1);
                  target_in   = '0;
                  progress_in = '0;
               end
            end
            default: begin
               phase_in    = PH_ARR_MARK;
               count_in    = '0;
               done_in     = '0;
               target_in   = '0;
               progress_in = '0;
            end
         endcase
      end
   end

   // Result word
   always_comb begin
      result.event_res    = EV_FRAME;
      result.data_byte    = '0;
      result.string_index = StringIndexBits'(done_ff);
      result.byte_offset  = '0;
      result.error_code   = err;
      if (err != ERR_NONE) begin
         result.event_res    = EV_ERROR;
         result.string_index = '0;
      end else begin
         unique case (phase_ff)
            PH_ARR_LF: begin
               if (count_ff == '0) result.event_res = EV_REQUEST;
            end
            PH_DATA: begin
               result.event_res   = EV_PAYLOAD;
               result.data_byte   = byte_in;
               result.byte_offset = OffsetBits'(progress_ff);
            end
            PH_TRAIL_LF: begin
               result.event_res = last_string ? EV_REQUEST : EV_STRING;
            end
            PH_ARR_MARK, PH_ARR_FIRST, PH_ARR_LEN, PH_STR_MARK, PH_STR_FIRST,
            PH_STR_LEN, PH_STR_LF, PH_TRAIL_CR: begin
               result.event_res = EV_FRAME;
            end
            default: begin
               result.string_index = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_ARR_MARK;
         count_ff    <= '0;
         done_ff     <= '0;
         target_ff   <= '0;
         progress_ff <= '0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         done_ff     <= done_in;
         target_ff   <= target_in;
         progress_ff <= progress_in;
      end
   end

endmodule

// File: src/rrp_out_stage.sv
// Result register of the RESP request parser, with valid/stall towards the sink.
// Depends on rrp_pkg.
module rrp_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  rrp_pkg::result_type result_in,
   output logic               advance,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rrp_pkg::result_type result_out
);
   import rrp_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff;

   // The register can take a new word when empty or being emptied.
   assign advance  = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign result_out = result_ff;

endmodule

// File: src/resp_request_parser.sv
// Top level of the RESP request parser: configuration registers and the three stages.
// Depends on rrp_pkg, rrp_in_stage, rrp_parser and rrp_out_stage.
//
//   channel  direction  handshake             words
//   req      in         req_valid/req_stall   one raw stream byte
//   rsp      out        rsp_valid/rsp_stall   one result per byte
//   csr      in         csr_write             register write, index + data
//
// One byte per cycle sustained while the sink does not stall; a taken byte waits in
// the input register until it is parsed into the result register and shown on rsp.
// Reset clears both stage valids, the frame state and the limits to their defaults.
// A stalled result holds; the input register still takes one more word behind it,
// and req_stall rises only when that word cannot move on.
module resp_request_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_byte_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [2:0]                        rsp_event_res,
   output logic [7:0]                        rsp_data_byte,
   output logic [rrp_pkg::StringIndexBits-1:0] rsp_string_index,
   output logic [rrp_pkg::OffsetBits-1:0]    rsp_byte_offset,
   output logic [3:0]                        rsp_error_code,
   input  logic                              csr_write,
   input  logic [rrp_pkg::CsrIndexBits-1:0]  csr_index,
   input  logic [rrp_pkg::CsrDataBits-1:0]   csr_wdata
);
   import rrp_pkg::*;

   logic [StrCfgBits-1:0] max_string_length_ff;
   logic [ArrCfgBits-1:0] max_array_length_ff;
   in_word_type           in_word;
   result_type            parse_result;
   result_type            out_result;
   logic                  advance;
   logic                  fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_string_length_ff <= StrCfgBits'(536870912);
         max_array_length_ff  <= ArrCfgBits'(1048576);
      end else if (csr_write) begin
         if (csr_index == CSR_MAX_STRING_LENGTH) begin
            max_string_length_ff <= csr_wdata[StrCfgBits-1:0];
         end
         if (csr_index == CSR_MAX_ARRAY_LENGTH) begin
            max_array_length_ff <= csr_wdata[ArrCfgBits-1:0];
         end
      end
   end

   assign fire = in_word.valid && advance;

   rrp_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_byte_in (req_byte_in),
      .advance     (advance),
      .word_out    (in_word)
   );

   rrp_parser u_parser (
      .clock             (clock),
      .reset             (reset),
      .fire              (fire),
      .byte_in           (in_word.byte_in),
      .max_string_length (max_string_length_ff),
      .max_array_length  (max_array_length_ff),
      .result            (parse_result)
   );

   rrp_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .result_in  (parse_result),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .result_out (out_result)
   );

   assign rsp_event_res    = out_result.event_res;
   assign rsp_data_byte    = out_result.data_byte;
   assign rsp_string_index = out_result.string_index;
   assign rsp_byte_offset  = out_result.byte_offset;
   assign rsp_error_code   = out_result.error_code;

   // Input side is held back only by a result the sink has not taken.
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled with no blocked result");

   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res == EV_ERROR) |->
         (rsp_string_index == '0 && rsp_error_code != ERR_NONE))
      else $error("error word with index or without code");

   a_code_only_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res != EV_ERROR) |-> (rsp_error_code == ERR_NONE))
      else $error("error code on a non-error word");

   a_payload_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res != EV_PAYLOAD) |->
         (rsp_data_byte == '0 && rsp_byte_offset == '0))
      else $error("data or offset on a non-payload word");

endmodule
